/* rtl/dis_pkg.sv */
// Shared types and constants for the depth image to scan bins unit.
// Holds item kind codes, reply codes, register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package dis_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_BIN_READ = 2'd1,
    KIND_FRAME    = 2'd2,
    KIND_NONE     = 2'd3
  } item_kind_t;

  localparam logic REPLY_BIN   = 1'b0;
  localparam logic REPLY_FRAME = 1'b1;

  localparam logic [2:0] REG_CENTER_COL     = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW     = 3'd1;
  localparam logic [2:0] REG_FOCAL_COL      = 3'd2;
  localparam logic [2:0] REG_FIRST_ANGLE    = 3'd3;
  localparam logic [2:0] REG_ANGLE_STEP     = 3'd4;
  localparam logic [2:0] REG_ROW_ANGLE_STEP = 3'd5;
  localparam logic [2:0] REG_HORIZON_OFFSET = 3'd6;
  localparam logic [2:0] REG_IMAGE_ROWS     = 3'd7;

  localparam int ATAN_LEN = 24;

  localparam logic signed [37:0] Q28_PI      = 38'sd843314857;
  localparam logic signed [37:0] Q28_HALF_PI = 38'sd421657428;
  localparam logic signed [37:0] Q28_TWO_PI  = 38'sd1686629713;
  localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;

  localparam logic signed [48:0] FLOOR_LOW  = 49'sd67108864000;
  localparam logic signed [48:0] FLOOR_HIGH = 49'sd88583700480;

  localparam logic [15:0] FLOOR_DEPTH_MAX = 16'd1000;
  localparam logic [15:0] RANGE_DEPTH_MAX = 16'd6000;
  localparam logic [12:0] KEEP_SHORTEST   = 13'd400;
  localparam logic [12:0] RANGE_FAR       = 13'd6000;
  localparam logic [12:0] RANGE_NEAR      = 13'd3000;
  localparam logic [11:0] BAND_HALF       = 12'd5;
  localparam logic [19:0] FLOOR_MAX       = 20'hFFFFF;

  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760959;
      5'd3:    v = 32'sd33381290;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/dis_if.sv */
// Valid/ready stream interfaces for the input items and the reply items.
// Depends on nothing; used by depth_image_to_scan_bins_unit.
`default_nettype none
interface dis_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  col;
  logic [9:0]  row;
  logic [15:0] depth_mm;
  modport source (output valid, kind, col, row, depth_mm, input ready);
  modport sink (input valid, kind, col, row, depth_mm, output ready);
endinterface

interface dis_out_if;
  logic        valid;
  logic        ready;
  logic        reply_kind;
  logic [12:0] range_mm;
  logic        range_valid;
  logic [19:0] floor_points;
  modport source (output valid, reply_kind, range_mm, range_valid, floor_points, input ready);
  modport sink (input valid, reply_kind, range_mm, range_valid, floor_points, output ready);
endinterface
`default_nettype wire

/* rtl/depth_image_to_scan_bins_unit.sv */
// Depth pixels to scan bins. One item at a time: a kept pixel passes through range reduction,
// shared CORDIC iterations, a 21-step bin divider, a 13-bit range search and a bin
// read-modify-write; rejected pixels end earlier, skipped ones at once.
// A bin read or a frame end goes through its reply state to the reply register, and waits
// there while the previous reply is not yet taken. After reset the bin memory is cleared,
// one bin a cycle, before the first item is taken. Depends on dis_pkg, dis_if and dis_ram.
`default_nettype none
module depth_image_to_scan_bins_unit #(
  parameter int BIN_COUNT    = 640,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dis_in_if.sink           in_ch,
  dis_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import dis_pkg::*;

  localparam int BIN_AW = $clog2(BIN_COUNT);
  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);
  localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(BIN_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_REDUCE, ST_FOLD, ST_CORDIC, ST_MUL, ST_DECIDE,
    ST_DIV, ST_SQRT, ST_LIMIT, ST_RMW, ST_BIN_REPLY, ST_FRAME_REPLY
  } state_t;

  state_t state_r;

  logic [13:0] center_col_r;
  logic [13:0] center_row_r;
  logic [15:0] focal_r;
  logic signed [18:0] first_angle_r;
  logic [16:0] angle_step_r;
  logic [20:0] row_step_r;
  logic signed [16:0] horizon_r;
  logic [10:0] image_rows_r;

  logic [19:0] floor_cnt_r;
  logic [BIN_AW-1:0] clr_r;
  logic [BIN_AW-1:0] bin_addr_r;
  logic bin_hit_r;

  logic [9:0]  row_r;
  logic [15:0] depth_r;
  logic signed [14:0] dc_r;
  logic signed [14:0] rdiff_r;
  logic signed [37:0] ya_r;
  logic [2:0] red_cnt_r;
  logic [4:0] it_r;
  logic signed [35:0] vx_r, vy_r;
  logic signed [31:0] vz_r;
  logic signed [31:0] sx_r, sy_r, sr_r;
  logic signed [48:0] p_r;
  logic [31:0] d2_r;
  logic [32:0] s_r;
  logic [58:0] n_r;
  logic [20:0] div_n_r;
  logic [17:0] rem_r;
  logic [20:0] quot_r;
  logic [12:0] k_r, cand_r;
  logic [28:0] pk_r;
  logic [3:0]  bit_r;
  logic        phase_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [12:0] out_range_r;
  logic        out_rvalid_r;
  logic [19:0] out_floor_r;

  logic        mem_we, mem_re;
  logic [BIN_AW-1:0] mem_waddr, mem_raddr;
  logic [13:0] mem_wdata, mem_rdata;

  logic in_acc, cfg_we, out_free, reply_go;
  logic [2:0] cfg_idx;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign reply_go = out_free && ((state_r == ST_BIN_REPLY) || (state_r == ST_FRAME_REPLY));

  assign out_ch.valid        = out_valid_r;
  assign out_ch.reply_kind   = out_kind_r;
  assign out_ch.range_mm     = out_range_r;
  assign out_ch.range_valid  = out_rvalid_r;
  assign out_ch.floor_points = out_floor_r;

  always_comb begin
    case (cfg_idx)
      REG_CENTER_COL:     prdata = {18'd0, center_col_r};
      REG_CENTER_ROW:     prdata = {18'd0, center_row_r};
      REG_FOCAL_COL:      prdata = {16'd0, focal_r};
      REG_FIRST_ANGLE:    prdata = {{13{first_angle_r[18]}}, first_angle_r};
      REG_ANGLE_STEP:     prdata = {15'd0, angle_step_r};
      REG_ROW_ANGLE_STEP: prdata = {11'd0, row_step_r};
      REG_HORIZON_OFFSET: prdata = {{15{horizon_r[16]}}, horizon_r};
      REG_IMAGE_ROWS:     prdata = {21'd0, image_rows_r};
      default:            prdata = 32'd0;
    endcase
  end

  logic in_col_hit;
  logic signed [14:0] in_dc, in_rdiff;
  assign in_col_hit = ({1'b0, in_ch.col} < 11'(BIN_COUNT));
  assign in_dc = $signed({1'b0, in_ch.col, 4'b0}) - $signed({1'b0, center_col_r});
  assign in_rdiff = $signed({1'b0, in_ch.row, 4'b0}) - $signed({1'b0, center_row_r});

  logic signed [36:0] ya_prod;
  logic signed [37:0] ya_sum;
  assign ya_prod = rdiff_r * $signed({1'b0, row_step_r});
  assign ya_sum = {ya_prod[36], ya_prod} + {{9{horizon_r[16]}}, horizon_r, 12'b0};

  logic signed [37:0] red_mult, fold_a, fold_b;
  assign red_mult = Q28_TWO_PI <<< (3'd5 - red_cnt_r);
  assign fold_a = (ya_r > Q28_PI) ? ya_r - Q28_TWO_PI : ya_r;
  always_comb begin
    if (fold_a > Q28_HALF_PI) begin
      fold_b = Q28_PI - fold_a;
    end else if (fold_a < -Q28_HALF_PI) begin
      fold_b = -Q28_PI - fold_a;
    end else begin
      fold_b = fold_a;
    end
  end

  logic signed [35:0] vx_sh, vy_sh;
  logic signed [31:0] sx_sh, sy_sh, at;
  assign vx_sh = vx_r >>> it_r;
  assign vy_sh = vy_r >>> it_r;
  assign sx_sh = sx_r >>> it_r;
  assign sy_sh = sy_r >>> it_r;
  assign at = atan_q28(it_r);

  logic signed [33:0] num;
  logic [13:0] dc_abs;
  logic [31:0] fc_sq;
  logic [27:0] dc_sq;
  assign num = -{{2{vz_r[31]}}, vz_r} - {{3{first_angle_r[18]}}, first_angle_r, 12'b0};
  assign dc_abs = dc_r[14] ? 14'(-dc_r) : dc_r[13:0];
  assign fc_sq = focal_r * focal_r;
  assign dc_sq = dc_abs * dc_abs;

  logic floor_hit;
  assign floor_hit = (p_r > FLOOR_LOW) && (p_r < FLOOR_HIGH);

  logic [16:0] step_eff;
  logic [18:0] rem_ext;
  logic rem_ge;
  assign step_eff = (angle_step_r == 17'd0) ? 17'd1 : angle_step_r;
  assign rem_ext = {rem_r, div_n_r[20]};
  assign rem_ge = rem_ext >= {2'b0, step_eff};

  logic [12:0] cand;
  logic [57:0] pk_sq;
  assign cand = k_r | (13'd1 << bit_r);
  assign pk_sq = pk_r * pk_r;

  logic [BIN_AW-1:0] bin_idx;
  logic [9:0] half;
  logic in_band;
  logic [12:0] limit;
  assign bin_idx = (quot_r > 21'(BIN_COUNT - 1)) ? LAST_BIN : quot_r[BIN_AW-1:0];
  assign half = image_rows_r[10:1];
  assign in_band = ({2'b0, row_r} + BAND_HALF >= {2'b0, half})
                && ({2'b0, row_r} <= {2'b0, half} + BAND_HALF);
  assign limit = in_band ? RANGE_FAR : RANGE_NEAR;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin_addr_r;
    mem_wdata = 14'd0;
    mem_re    = 1'b0;
    mem_raddr = bin_idx;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      ST_IDLE: begin
        mem_raddr = in_ch.col[BIN_AW-1:0];
        mem_re    = in_acc && (in_ch.kind == KIND_BIN_READ) && in_col_hit;
      end
      ST_LIMIT: begin
        mem_re = (k_r >= KEEP_SHORTEST) && (k_r <= limit);
      end
      ST_RMW: begin
        mem_waddr = bin_addr_r;
        mem_wdata = {1'b1, k_r};
        mem_we    = !(mem_rdata[13] && (k_r >= mem_rdata[12:0]));
      end
      ST_BIN_REPLY: begin
        mem_we = out_free && bin_hit_r;
      end
      default: begin
      end
    endcase
  end

  dis_ram #(.WIDTH(14), .DEPTH(BIN_COUNT)) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      floor_cnt_r   <= 20'd0;
      out_valid_r   <= 1'b0;
      center_col_r  <= 14'd5120;
      center_row_r  <= 14'd3840;
      focal_r       <= 16'd9600;
      first_angle_r <= -19'sd32768;
      angle_step_r  <= 17'd103;
      row_step_r    <= 21'd27000;
      horizon_r     <= 17'sd0;
      image_rows_r  <= 11'd480;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_CENTER_COL:     center_col_r  <= pwdata[13:0];
          REG_CENTER_ROW:     center_row_r  <= pwdata[13:0];
          REG_FOCAL_COL:      focal_r       <= pwdata[15:0];
          REG_FIRST_ANGLE:    first_angle_r <= $signed(pwdata[18:0]);
          REG_ANGLE_STEP:     angle_step_r  <= pwdata[16:0];
          REG_ROW_ANGLE_STEP: row_step_r    <= pwdata[20:0];
          REG_HORIZON_OFFSET: horizon_r     <= $signed(pwdata[16:0]);
          REG_IMAGE_ROWS:     image_rows_r  <= pwdata[10:0];
          default: begin
          end
        endcase
      end
      if (reply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_BIN) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          row_r      <= in_ch.row;
          depth_r    <= in_ch.depth_mm;
          dc_r       <= in_dc;
          rdiff_r    <= in_rdiff;
          bin_addr_r <= in_ch.col[BIN_AW-1:0];
          bin_hit_r  <= in_col_hit;
          if (in_acc) begin
            case (in_ch.kind)
              KIND_PIXEL: begin
                if (in_ch.row[0] && (in_ch.depth_mm != 16'd0)) begin
                  state_r <= ST_PREP;
                end
              end
              KIND_BIN_READ: state_r <= ST_BIN_REPLY;
              KIND_FRAME:    state_r <= ST_FRAME_REPLY;
              default: begin
              end
            endcase
          end
        end
        ST_PREP: begin
          ya_r      <= ya_sum;
          red_cnt_r <= 3'd0;
          vx_r      <= {4'b0, focal_r, 16'b0};
          vy_r      <= {{5{dc_r[14]}}, dc_r, 16'b0};
          vz_r      <= 32'sd0;
          sx_r      <= Q28_GAIN;
          sy_r      <= 32'sd0;
          it_r      <= 5'd0;
          state_r   <= ST_REDUCE;
        end
        ST_REDUCE: begin
          red_cnt_r <= red_cnt_r + 1'b1;
          if (red_cnt_r == 3'd0) begin
            if (ya_r < 0) begin
              ya_r <= ya_r + (Q28_TWO_PI <<< 5);
            end
          end else if (ya_r >= red_mult) begin
            ya_r <= ya_r - red_mult;
          end
          if (red_cnt_r == 3'd5) begin
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          sr_r    <= fold_b[31:0];
          state_r <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (!vy_r[35]) begin
            vx_r <= vx_r + vy_sh;
            vy_r <= vy_r - vx_sh;
            vz_r <= vz_r + at;
          end else begin
            vx_r <= vx_r - vy_sh;
            vy_r <= vy_r + vx_sh;
            vz_r <= vz_r - at;
          end
          if (!sr_r[31]) begin
            sx_r <= sx_r - sy_sh;
            sy_r <= sy_r + sx_sh;
            sr_r <= sr_r - at;
          end else begin
            sx_r <= sx_r + sy_sh;
            sy_r <= sy_r - sx_sh;
            sr_r <= sr_r + at;
          end
          it_r <= it_r + 1'b1;
          if (it_r == LAST_STEP) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          p_r     <= $signed({1'b0, depth_r}) * sy_r;
          d2_r    <= depth_r * depth_r;
          s_r     <= {1'b0, fc_sq} + {5'b0, dc_sq};
          div_n_r <= num[33] ? 21'd0 : num[32:12];
          rem_r   <= 18'd0;
          quot_r  <= 21'd0;
          it_r    <= 5'd0;
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          n_r     <= d2_r[25:0] * s_r;
          k_r     <= 13'd0;
          bit_r   <= 4'd12;
          phase_r <= 1'b0;
          if (floor_hit) begin
            if ((depth_r <= FLOOR_DEPTH_MAX) && (floor_cnt_r != FLOOR_MAX)) begin
              floor_cnt_r <= floor_cnt_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end else if ((focal_r == 16'd0) || (depth_r > RANGE_DEPTH_MAX)) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r   <= rem_ge ? 18'(rem_ext - {2'b0, step_eff}) : rem_ext[17:0];
          quot_r  <= {quot_r[19:0], rem_ge};
          div_n_r <= {div_n_r[19:0], 1'b0};
          it_r    <= it_r + 1'b1;
          if (it_r == 5'd20) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          phase_r <= !phase_r;
          if (!phase_r) begin
            cand_r <= cand;
            pk_r   <= cand * focal_r;
          end else begin
            if ({1'b0, pk_sq} <= n_r) begin
              k_r <= cand_r;
            end
            bit_r <= bit_r - 1'b1;
            if (bit_r == 4'd0) begin
              state_r <= ST_LIMIT;
            end
          end
        end
        ST_LIMIT: begin
          bin_addr_r <= bin_idx;
          state_r    <= mem_re ? ST_RMW : ST_IDLE;
        end
        ST_RMW: begin
          state_r <= ST_IDLE;
        end
        ST_BIN_REPLY: begin
          if (out_free) begin
            out_kind_r   <= REPLY_BIN;
            out_rvalid_r <= bin_hit_r && mem_rdata[13];
            out_range_r  <= (bin_hit_r && mem_rdata[13]) ? mem_rdata[12:0] : 13'd0;
            out_floor_r  <= 20'd0;
            state_r      <= ST_IDLE;
          end
        end
        ST_FRAME_REPLY: begin
          if (out_free) begin
            out_kind_r   <= REPLY_FRAME;
            out_rvalid_r <= 1'b0;
            out_range_r  <= 13'd0;
            out_floor_r  <= floor_cnt_r;
            floor_cnt_r  <= 20'd0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/dis_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none
module dis_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 640
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* test/dis_tb_items.sv */
// Transaction types shared by the testbench of the depth image to scan bins unit.
// Depends on dis_pkg for the item kind codes.
package dis_tb_items;
  import dis_pkg::*;

  typedef struct {
    item_kind_t  kind;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] depth_mm;
  } scan_item_t;

  typedef struct {
    logic        reply_kind;
    logic [12:0] range_mm;
    logic        range_valid;
    logic [19:0] floor_points;
  } scan_reply_t;
endpackage

/* test/testbench.sv */
// Self-checking testbench for depth_image_to_scan_bins_unit: random and directed pixel,
// bin read and frame end transactions checked against an in-bench scan-bin predictor.
// Depends on dis_pkg, dis_if, dis_tb_items and the unit itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dis_pkg::*;
  import dis_tb_items::*;

  localparam int NBINS = 640;
  localparam int STEPS = 16;
  localparam longint TWO_PI = 1686629713;
  localparam longint PI = 843314857;
  localparam longint HALF_PI = 421657428;
  localparam longint GAIN = 163008219;
  localparam longint ATAN [16] = '{210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  dis_in_if in_if();
  dis_out_if out_if();

  depth_image_to_scan_bins_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  logic [13:0] c_center_col, c_center_row;
  logic [15:0] c_focal_col;
  logic signed [18:0] c_first_angle;
  logic [16:0] c_angle_step;
  logic [20:0] c_row_step;
  logic signed [16:0] c_horizon;
  logic [10:0] c_image_rows;

  logic [13:0] scan_words [NBINS];
  int unsigned floor_count;

  scan_item_t pending_items[$];
  scan_reply_t expected_replies[$];
  int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
  int errors = 0, n_pixels = 0, n_reads = 0, n_frames = 0, n_replies = 0, n_kept = 0;
  int recent_cols[$];

  function automatic longint column_angle(longint xi, longint yi);
    longint x, y, z, nx, ny;
    x = xi * 65536;
    y = yi * 65536;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint row_sine(longint a);
    longint x, y, r, nx, ny;
    x = GAIN; y = 0;
    r = a % TWO_PI;
    if (r < 0) r += TWO_PI;
    if (r > PI) r -= TWO_PI;
    if (r > HALF_PI) r = PI - r;
    else if (r < -HALF_PI) r = -PI - r;
    for (int i = 0; i < STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); r -= ATAN[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); r += ATAN[i];
      end
      x = nx; y = ny;
    end
    return y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int bin_of_column(logic [9:0] col);
    longint th, num, den, idx;
    th = -column_angle(longint'(c_focal_col), longint'(col) * 16 - longint'(c_center_col));
    num = th - longint'(c_first_angle) * 4096;
    den = longint'(c_angle_step == 0 ? 17'd1 : c_angle_step) * 4096;
    idx = num < 0 ? 0 : num / den;
    if (idx > NBINS - 1) idx = NBINS - 1;
    return int'(idx);
  endfunction

  function automatic void bin_pixel(logic [9:0] col, logic [9:0] row, logic [15:0] depth);
    longint ya, p, dc, half, lim;
    longint unsigned fc2, q, r;
    int idx;
    if (row[0] == 1'b0 || depth == 0) return;
    dc = longint'(col) * 16 - longint'(c_center_col);
    idx = bin_of_column(col);
    ya = (longint'(row) * 16 - longint'(c_center_row)) * longint'(c_row_step)
         + longint'(c_horizon) * 4096;
    p = longint'(depth) * row_sine(ya);
    if (p > 250 * 64'sd268435456 && p < 330 * 64'sd268435456) begin
      if (depth <= 1000 && floor_count < 20'hFFFFF) floor_count++;
      return;
    end
    if (c_focal_col == 0 || depth > 6000) return;
    fc2 = longint'(c_focal_col) * longint'(c_focal_col);
    q = longint'(depth) * longint'(depth) * (fc2 + longint'(dc * dc)) / fc2;
    r = int_sqrt(q);
    half = longint'(c_image_rows / 2);
    lim = (longint'(row) >= half - 5 && longint'(row) <= half + 5) ? 6000 : 3000;
    if (r < 400 || r > lim) return;
    if (scan_words[idx][13] && r >= scan_words[idx][12:0]) return;
    scan_words[idx] = {1'b1, 13'(r)};
    n_kept++;
  endfunction

  function automatic void predict_item(scan_item_t it);
    scan_reply_t rp;
    rp = '{reply_kind: REPLY_BIN, range_mm: 0, range_valid: 0, floor_points: 0};
    case (it.kind)
      KIND_PIXEL: begin
        n_pixels++;
        bin_pixel(it.col, it.row, it.depth_mm);
      end
      KIND_BIN_READ: begin
        n_reads++;
        if (it.col < NBINS) begin
          rp.range_valid = scan_words[it.col][13];
          rp.range_mm = scan_words[it.col][13] ? scan_words[it.col][12:0] : 13'd0;
          scan_words[it.col] = 0;
        end
        expected_replies.push_back(rp);
      end
      KIND_FRAME: begin
        n_frames++;
        rp.reply_kind = REPLY_FRAME;
        rp.floor_points = floor_count[19:0];
        floor_count = 0;
        expected_replies.push_back(rp);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        scan_item_t it;
        it = pending_items.pop_front();
        in_if.valid <= 1;
        in_if.kind <= it.kind;
        in_if.col <= it.col;
        in_if.row <= it.row;
        in_if.depth_mm <= it.depth_mm;
      end else begin
        in_if.valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 0;
    end else begin
      out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      scan_item_t it;
      it.kind = item_kind_t'(in_if.kind);
      it.col = in_if.col;
      it.row = in_if.row;
      it.depth_mm = in_if.depth_mm;
      predict_item(it);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      scan_reply_t ex;
      n_replies++;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply kind %0b range %0d valid %0b floor %0d", $time,
                 out_if.reply_kind, out_if.range_mm, out_if.range_valid, out_if.floor_points);
      end else begin
        ex = expected_replies.pop_front();
        if (out_if.reply_kind !== ex.reply_kind || out_if.range_mm !== ex.range_mm ||
            out_if.range_valid !== ex.range_valid || out_if.floor_points !== ex.floor_points)
        begin
          errors++;
          $display("%0t: mismatch expected kind %0b range %0d valid %0b floor %0d, got %0b %0d %0b %0d",
                   $time, ex.reply_kind, ex.range_mm, ex.range_valid, ex.floor_points,
                   out_if.reply_kind, out_if.range_mm, out_if.range_valid, out_if.floor_points);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_CENTER_COL: c_center_col = value[13:0];
      REG_CENTER_ROW: c_center_row = value[13:0];
      REG_FOCAL_COL: c_focal_col = value[15:0];
      REG_FIRST_ANGLE: c_first_angle = value[18:0];
      REG_ANGLE_STEP: c_angle_step = value[16:0];
      REG_ROW_ANGLE_STEP: c_row_step = value[20:0];
      REG_HORIZON_OFFSET: c_horizon = value[16:0];
      default: c_image_rows = value[10:0];
    endcase
  endtask

  task automatic set_all(int cc, int cr, int fc, int fa, int ast, int rs, int ho, int ir);
    write_reg(REG_CENTER_COL, cc);
    write_reg(REG_CENTER_ROW, cr);
    write_reg(REG_FOCAL_COL, fc);
    write_reg(REG_FIRST_ANGLE, fa & 32'h7FFFF);
    write_reg(REG_ANGLE_STEP, ast);
    write_reg(REG_ROW_ANGLE_STEP, rs);
    write_reg(REG_HORIZON_OFFSET, ho & 32'h1FFFF);
    write_reg(REG_IMAGE_ROWS, ir);
  endtask

  task automatic push_item(item_kind_t k, int col, int row, int depth);
    pending_items.push_back('{kind: k, col: 10'(col), row: 10'(row), depth_mm: 16'(depth)});
  endtask

  task automatic push_random(int count);
    int k, row, depth, col;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 68) begin
        col = $urandom_range(1023);
        if ($urandom_range(99) < 40) row = c_image_rows / 2 - 6 + $urandom_range(12);
        else row = $urandom_range(1023);
        row = ($urandom_range(99) < 85) ? (row | 1) : (row & ~1);
        row = row & 10'h3FF;
        case ($urandom_range(9))
          0: depth = 0;
          1, 2, 3, 4: depth = $urandom_range(6000, 400);
          5, 6, 7: depth = $urandom_range(1200);
          default: depth = $urandom_range(65535);
        endcase
        push_item(KIND_PIXEL, col, row, depth);
        recent_cols.push_back(col);
        if (recent_cols.size() > 8) void'(recent_cols.pop_front());
      end else if (k < 90) begin
        if ($urandom_range(9) < 6 && recent_cols.size() > 0)
          col = bin_of_column(10'(recent_cols[$urandom_range(recent_cols.size() - 1)]));
        else if ($urandom_range(9) < 8) col = $urandom_range(NBINS - 1);
        else col = $urandom_range(1023, NBINS);
        push_item(KIND_BIN_READ, col, $urandom_range(1023), $urandom_range(65535));
      end else if (k < 97) begin
        push_item(KIND_FRAME, $urandom_range(1023), $urandom_range(1023), $urandom_range(65535));
      end else begin
        push_item(KIND_NONE, $urandom_range(1023), $urandom_range(1023), $urandom_range(65535));
        n--;
      end
    end
  endtask

  task automatic drain();
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_if.valid || expected_replies.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    in_if.valid = 0; in_if.kind = KIND_PIXEL; in_if.col = 0; in_if.row = 0; in_if.depth_mm = 0;
    out_if.ready = 0;
    c_center_col = 5120; c_center_row = 3840; c_focal_col = 9600; c_first_angle = -32768;
    c_angle_step = 103; c_row_step = 27000; c_horizon = 0; c_image_rows = 480;
    foreach (scan_words[i]) scan_words[i] = 0;
    floor_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    push_item(KIND_PIXEL, 0, 241, 1000);
    push_item(KIND_PIXEL, 1023, 239, 6000);
    push_item(KIND_PIXEL, 320, 240, 2000);
    push_item(KIND_PIXEL, 320, 241, 0);
    push_item(KIND_PIXEL, 320, 1023, 65535);
    push_item(KIND_PIXEL, 320, 241, 400);
    push_item(KIND_PIXEL, 320, 241, 399);
    push_item(KIND_PIXEL, 320, 1, 2500);
    push_item(KIND_PIXEL, 320, 401, 500);
    push_item(KIND_PIXEL, 320, 451, 600);
    push_item(KIND_BIN_READ, bin_of_column(320), 0, 0);
    push_item(KIND_BIN_READ, bin_of_column(0), 1023, 65535);
    push_item(KIND_BIN_READ, bin_of_column(1023), 0, 0);
    push_item(KIND_BIN_READ, 1023, 0, 0);
    push_item(KIND_BIN_READ, NBINS, 0, 0);
    push_item(KIND_BIN_READ, 0, 0, 0);
    push_item(KIND_NONE, 1023, 1023, 65535);
    push_item(KIND_FRAME, 0, 0, 0);
    push_item(KIND_FRAME, 1023, 1023, 65535);
    push_random(300);
    drain();

    set_all($urandom_range(16383), $urandom_range(16383), $urandom_range(65535, 16),
            $urandom_range(411774) - 205887, $urandom_range(65536, 1),
            $urandom_range(1048576), $urandom_range(65536) - 32768, $urandom_range(1024, 2));
    send_idle_pct = 87;
    push_random(300);
    drain();

    set_all(5120, 3840, 9600, -32768, 103, 27000, 0, 480);
    send_idle_pct = 0; recv_stall_pct = 87;
    @(negedge clk);
    hold_cycles = 3000;
    push_random(320);
    drain();

    set_all(16383, 16383, 65535, 205887, 65536, 1048576, 32768, 1024);
    send_idle_pct = 25; recv_stall_pct = 25;
    push_random(250);
    drain();

    set_all(0, 0, 0, -205887, 0, 0, -32768, 2);
    send_idle_pct = 0; recv_stall_pct = 0;
    push_random(150);
    drain();

    set_all($urandom_range(6000, 4000), $urandom_range(16383), $urandom_range(16000, 6000),
            -32768, $urandom_range(200, 1), $urandom_range(60000), $urandom_range(65536) - 32768,
            $urandom_range(1024, 2));
    send_idle_pct = 25; recv_stall_pct = 25;
    push_random(330);
    drain();

    $display("Covered %0d pixels (%0d kept), %0d bin reads, %0d frame ends, %0d replies",
             n_pixels, n_kept, n_reads, n_frames, n_replies);
    $display("over six register settings with idle, stall and long hold-off phases.");
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
